FILE: hw/rtl/lxr_pkg.sv
// lxr_pkg: sizes, constants, command codes and the controller command struct
// for the lookup xor-shift hash. No dependencies.
package lxr_pkg;

  // lookup table and message buffer sizing
  localparam int unsigned MAP_BITS   = 16;
  localparam int unsigned MAX_LEN    = 64;
  localparam int unsigned LEN_W      = $clog2(MAX_LEN + 1);
  localparam int unsigned MSG_AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned DIGEST_LEN = 32;
  localparam int unsigned HIDX_W     = 5;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned PASS_W     = 5;

  // last table step of one full mix
  localparam logic [STEP_W-1:0] FULL_STEPS = 5'd25;
  localparam logic [HIDX_W-1:0] LAST_POS   = 5'd31;

  // seeds and generator keys
  localparam logic [63:0] SEED_RESET     = 64'hFAFAECECFAFAECEC;
  localparam logic [63:0] GEN_OFFSET_KEY = 64'd2458719153079158768;
  localparam logic [63:0] GEN_B_KEY      = 64'd4631534797403582785;
  localparam logic [63:0] GEN_V_INIT     = 64'd3523455478921636871;
  localparam logic [4:0]  PASSES_RESET   = 5'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PASSES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 1'd1;

  // input operation codes
  typedef enum logic [1:0] {
    OP_BUILD  = 2'd0,
    OP_ABSORB = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // datapath commands
  typedef enum logic [4:0] {
    CMD_IDLE       = 5'd0,
    CMD_FILL_WR    = 5'd1,
    CMD_GEN_INIT   = 5'd2,
    CMD_GEN_RD     = 5'd3,
    CMD_GEN_UPD    = 5'd4,
    CMD_SW_RDJ     = 5'd5,
    CMD_SW_WRI     = 5'd6,
    CMD_SW_WRJ     = 5'd7,
    CMD_MSG_WR     = 5'd8,
    CMD_HASH_INIT  = 5'd9,
    CMD_MSG_RD     = 5'd10,
    CMD_LOAD_BYTE  = 5'd11,
    CMD_MIX_RD     = 5'd12,
    CMD_MIX_UPD    = 5'd13,
    CMD_FULL_END   = 5'd14,
    CMD_LOAD_FINAL = 5'd15,
    CMD_OUT_RD1    = 5'd16,
    CMD_OUT_RD2    = 5'd17,
    CMD_OUT_SET    = 5'd18
  } cmd_e;

  typedef struct packed {
    cmd_e                op;
    logic [MAP_BITS-1:0] tidx;
    logic [MSG_AW-1:0]   midx;
    logic [HIDX_W-1:0]   hidx;
    logic [STEP_W-1:0]   step;
    logic                last;
    logic                ovf;
  } ctrl_cmd_t;

endpackage

FILE: hw/rtl/lxr_if.sv
// lxr_in_if / lxr_out_if: valid-ready channels of the hash block
// no dependencies
interface lxr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] message_byte;
  logic       last_byte;

  modport source (output valid, operation, message_byte, last_byte, input ready);
  modport sink (input valid, operation, message_byte, last_byte, output ready);
  modport monitor (input valid, ready, operation, message_byte, last_byte);
endinterface

interface lxr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  logic [4:0] byte_position;
  logic       last_of_digest;
  logic       message_too_long;

  modport source (output valid, digest_byte, byte_position, last_of_digest,
                  message_too_long, input ready);
  modport sink (input valid, digest_byte, byte_position, last_of_digest,
                message_too_long, output ready);
  modport monitor (input valid, ready, digest_byte, byte_position, last_of_digest,
                   message_too_long);
endinterface

FILE: hw/rtl/lxr_ram.sv
// lxr_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module lxr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lxr_datapath.sv
// lxr_datapath: lookup table and message rams, generator, mixing registers,
// hash words and output payload; uses lxr_pkg and lxr_ram
module lxr_datapath
  import lxr_pkg::*;
(
  input  logic       clk_i,
  input  ctrl_cmd_t  cmd_i,
  input  logic [63:0] seed_i,
  input  logic [7:0] msg_byte_i,
  output logic [7:0] digest_byte_o,
  output logic [4:0] byte_position_o,
  output logic       last_of_digest_o,
  output logic       message_too_long_o
);

  logic                tbl_we;
  logic [MAP_BITS-1:0] tbl_waddr;
  logic [7:0]          tbl_wdata;
  logic [MAP_BITS-1:0] tbl_raddr;
  logic [7:0]          tbl_rdata;
  logic                msg_we;
  logic [7:0]          msg_rdata;

  // generator, mixing and hash state
  logic [63:0] off_q, gb_q, gv_q;
  logic [7:0]  ti_q;
  logic [63:0] as_q, s1_q, s2_q, h_q, v2_q;
  logic [63:0] m0_q, m1_q, m2_q;
  logic [63:0] hw_q [DIGEST_LEN];
  logic [7:0]  ob_q;
  logic [7:0]  out_byte_q;
  logic [4:0]  out_pos_q;
  logic        out_last_q, out_ovf_q;

  logic [63:0] t64, off_n, gv_n, gb_n;
  logic [63:0] maddr, as_n, s1_n, s2_n, h_n, s1t, fast_s1, hw_sel;

  assign t64    = {56'd0, tbl_rdata};
  assign hw_sel = hw_q[cmd_i.hidx];

  lxr_ram #(.WIDTH(8), .DEPTH(2 ** MAP_BITS)) u_tbl_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  lxr_ram #(.WIDTH(8), .DEPTH(2 ** MSG_AW)) u_msg_ram (
    .clk_i  (clk_i),
    .we_i   (msg_we),
    .waddr_i(cmd_i.midx),
    .wdata_i(msg_byte_i),
    .raddr_i(cmd_i.midx),
    .rdata_o(msg_rdata)
  );

  // shuffle generator next values
  always_comb begin
    off_n = (off_q << 9) ^ (off_q >> 1) ^ (off_q >> 7) ^ gb_q;
    gv_n  = t64 ^ (gv_q << 8) ^ (gv_q >> 1);
    gb_n  = (gv_n << 7) ^ (gv_n << 13) ^ (gv_n << 33) ^ (gv_n << 52) ^
            (gb_q << 9) ^ (gb_q >> 1);
  end

  // one table step of the mixing functions, selected by step index
  always_comb begin
    maddr = '0;
    as_n  = as_q;
    s1_n  = s1_q;
    s2_n  = s2_q;
    h_n   = h_q;
    s1t   = '0;
    case (cmd_i.step)
      5'd0: begin
        maddr = as_q ^ v2_q;
        as_n  = (as_q << 7) ^ (as_q >> 5) ^ (v2_q << 20) ^ (v2_q << 16) ^ v2_q ^
                (t64 << 20) ^ (t64 << 12) ^ (t64 << 4);
      end
      5'd1: begin
        maddr = (as_q >> 5) ^ v2_q;
        s1_n  = (s1_q << 9) ^ (s1_q >> 1) ^ as_q ^ (t64 << 3);
      end
      5'd2: begin
        maddr = s1_q ^ v2_q;
        s1_n  = (s1_q << 5) ^ (s1_q >> 3) ^ (t64 << 7);
      end
      5'd3: begin
        maddr = as_q ^ (s1_q >> 7);
        s1_n  = (s1_q << 7) ^ (s1_q >> 7) ^ (t64 << 5);
      end
      5'd4: begin
        maddr = v2_q ^ (as_q >> 11) ^ s1_q;
        s1t   = (s1_q << 11) ^ (s1_q >> 5) ^ (t64 << 27);
        s1_n  = s1t;
        h_n   = s1t ^ as_q ^ (h_q << 7) ^ (h_q >> 13);
      end
      5'd5: begin
        maddr = as_q ^ (s1_q >> 27) ^ v2_q;
        as_n  = (as_q << 17) ^ (as_q >> 5) ^ s1_q ^ (t64 << 3);
      end
      5'd6: begin
        maddr = as_q ^ s1_q;
        as_n  = (as_q << 13) ^ (as_q >> 3) ^ (t64 << 7);
      end
      5'd7: begin
        maddr = (as_q >> 7) ^ s1_q;
        as_n  = (as_q << 15) ^ (as_q >> 7) ^ (t64 << 11);
      end
      5'd8: begin
        maddr = v2_q ^ as_q ^ s1_q;
        as_n  = (as_q << 9) ^ (as_q >> 11) ^ (t64 << 3);
      end
      5'd9: begin
        maddr = as_q >> 3;
        s1_n  = (s1_q << 7) ^ (s1_q >> 27) ^ as_q ^ (t64 << 13);
      end
      5'd10: begin
        maddr = s1_q ^ v2_q;
        s1_n  = (s1_q << 3) ^ (s1_q >> 13) ^ (t64 << 11);
      end
      5'd11: begin
        maddr = as_q ^ (s1_q >> 11);
        s1_n  = (s1_q << 8) ^ (s1_q >> 11) ^ (t64 << 9);
      end
      5'd12: begin
        maddr = v2_q ^ as_q ^ s1_q;
        s1_n  = (s1_q << 6) ^ (s1_q >> 9) ^ (t64 << 3);
      end
      5'd13: begin
        maddr = as_q ^ v2_q ^ (s1_q >> 3);
        as_n  = (as_q << 23) ^ (as_q >> 3) ^ s1_q ^ (t64 << 7);
      end
      5'd14: begin
        maddr = as_q ^ (s1_q >> 3);
        as_n  = (as_q << 17) ^ (as_q >> 7) ^ (t64 << 5);
      end
      5'd15: begin
        maddr = (as_q >> 5) ^ s1_q;
        as_n  = (as_q << 13) ^ (as_q >> 5) ^ (t64 << 1);
      end
      5'd16: begin
        maddr = v2_q ^ as_q ^ s1_q;
        as_n  = (as_q << 11) ^ (as_q >> 1) ^ (t64 << 7);
      end
      5'd17: begin
        maddr = (as_q >> 7) ^ (s1_q >> 3);
        s1_n  = (s1_q << 5) ^ (s1_q >> 3) ^ as_q ^ (t64 << 6);
      end
      5'd18: begin
        maddr = s1_q ^ v2_q;
        s1_n  = (s1_q << 8) ^ (s1_q >> 6) ^ (t64 << 11);
      end
      5'd19: begin
        maddr = as_q ^ (s1_q >> 11);
        s1_n  = (s1_q << 11) ^ (s1_q >> 11) ^ (t64 << 5);
      end
      5'd20: begin
        maddr = v2_q ^ (as_q >> 7) ^ as_q ^ s1_q;
        s1_n  = (s1_q << 7) ^ (s1_q >> 5) ^ (t64 << 17);
      end
      5'd21: begin
        maddr = as_q ^ (s2_q >> 5) ^ v2_q;
        s2_n  = (s2_q << 3) ^ (s2_q >> 17) ^ s1_q ^ (t64 << 13);
      end
      5'd22: begin
        maddr = s2_q;
        s2_n  = (s2_q << 6) ^ (s2_q >> 13) ^ (t64 << 11);
      end
      5'd23: begin
        maddr = as_q ^ s1_q ^ (s2_q >> 11);
        s2_n  = (s2_q << 11) ^ (s2_q >> 11) ^ (t64 << 23);
      end
      5'd24: begin
        maddr = v2_q ^ (as_q >> 8) ^ as_q ^ (s2_q >> 10);
        s2_n  = (s2_q << 4) ^ (s2_q >> 23) ^ (t64 << 1);
      end
      5'd25: begin
        maddr = (s2_q >> 1) ^ h_q;
        s1t   = (s2_q << 3) ^ (s2_q >> 1) ^ h_q ^ v2_q;
        s1_n  = s1t;
        as_n  = (as_q << 9) ^ (as_q >> 7) ^ (s1t >> 1) ^ (t64 << 5);
      end
      default: begin
        maddr = '0;
      end
    endcase
  end

  assign fast_s1 = (m0_q << 9) ^ (m0_q >> 3) ^ hw_sel;

  // ram address and write selection
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = cmd_i.tidx;
    tbl_wdata = cmd_i.tidx[7:0];
    tbl_raddr = maddr[MAP_BITS-1:0];
    msg_we    = 1'b0;
    case (cmd_i.op)
      // keep the hash word lookup on the read port while the output waits
      CMD_IDLE: begin
        tbl_raddr = hw_sel[MAP_BITS-1:0];
      end
      CMD_FILL_WR: begin
        tbl_we = 1'b1;
      end
      CMD_GEN_RD: begin
        tbl_raddr = off_n[MAP_BITS-1:0] ^ gb_q[MAP_BITS-1:0];
      end
      CMD_GEN_UPD: begin
        tbl_raddr = cmd_i.tidx;
      end
      CMD_SW_RDJ: begin
        tbl_raddr = off_q[MAP_BITS-1:0];
      end
      CMD_SW_WRI: begin
        tbl_we    = 1'b1;
        tbl_wdata = tbl_rdata;
      end
      CMD_SW_WRJ: begin
        tbl_we    = 1'b1;
        tbl_waddr = off_q[MAP_BITS-1:0];
        tbl_wdata = ti_q;
      end
      CMD_MSG_WR: begin
        msg_we = 1'b1;
      end
      CMD_OUT_RD1: begin
        tbl_raddr = as_q[MAP_BITS-1:0];
      end
      CMD_OUT_RD2: begin
        tbl_raddr = hw_sel[MAP_BITS-1:0];
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_GEN_INIT: begin
        off_q <= seed_i ^ GEN_OFFSET_KEY;
        gb_q  <= seed_i ^ GEN_B_KEY;
        gv_q  <= GEN_V_INIT;
      end
      CMD_GEN_RD: begin
        off_q <= off_n;
      end
      CMD_GEN_UPD: begin
        gv_q <= gv_n;
        gb_q <= gb_n;
      end
      CMD_SW_RDJ: begin
        ti_q <= tbl_rdata;
      end
      CMD_HASH_INIT: begin
        for (int k = 0; k < DIGEST_LEN; k++) begin
          hw_q[k] <= '0;
        end
        as_q <= seed_i;
        m0_q <= '0;
        m1_q <= '0;
        m2_q <= '0;
      end
      CMD_LOAD_BYTE: begin
        v2_q <= {56'd0, msg_rdata};
        s1_q <= m0_q;
        s2_q <= m1_q;
        h_q  <= hw_sel;
      end
      CMD_LOAD_FINAL: begin
        v2_q <= hw_sel;
        s1_q <= m0_q;
        s2_q <= m1_q;
        h_q  <= hw_sel;
      end
      CMD_MIX_UPD: begin
        as_q <= as_n;
        if (cmd_i.step == '0) begin
          // fast mix commits at once
          hw_q[cmd_i.hidx] <= fast_s1 ^ as_n;
          m0_q <= m2_q;
          m1_q <= fast_s1;
          m2_q <= m1_q;
        end else begin
          s1_q <= s1_n;
          s2_q <= s2_n;
          h_q  <= h_n;
        end
      end
      CMD_FULL_END: begin
        hw_q[cmd_i.hidx] <= h_q;
        m0_q <= m2_q;
        m1_q <= s1_q;
        m2_q <= s2_q;
      end
      CMD_OUT_RD2: begin
        ob_q <= tbl_rdata;
      end
      CMD_OUT_SET: begin
        out_byte_q <= ob_q ^ tbl_rdata;
        out_pos_q  <= cmd_i.hidx;
        out_last_q <= cmd_i.last;
        out_ovf_q  <= cmd_i.ovf;
      end
      default: begin
        ti_q <= ti_q;
      end
    endcase
  end

  assign digest_byte_o      = out_byte_q;
  assign byte_position_o    = out_pos_q;
  assign last_of_digest_o   = out_last_q;
  assign message_too_long_o = out_ovf_q;

endmodule

FILE: hw/rtl/lxr_ctrl.sv
// lxr_ctrl: sequencer for table build, message buffering and digest steps;
// uses lxr_pkg, drives lxr_datapath through a command struct
module lxr_ctrl
  import lxr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [4:0]  passes_i,
  output ctrl_cmd_t   cmd_o
);

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_FILL  = 18'h00002,
    ST_G0    = 18'h00004,
    ST_G1    = 18'h00008,
    ST_G2    = 18'h00010,
    ST_G3    = 18'h00020,
    ST_G4    = 18'h00040,
    ST_HINIT = 18'h00080,
    ST_MRD   = 18'h00100,
    ST_MLD   = 18'h00200,
    ST_XRD   = 18'h00400,
    ST_XUP   = 18'h00800,
    ST_XEND  = 18'h01000,
    ST_FLD   = 18'h02000,
    ST_O1    = 18'h04000,
    ST_O2    = 18'h08000,
    ST_O3    = 18'h10000,
    ST_SPARE = 18'h20000
  } state_e;

  state_e              state_q, state_d;
  logic [MAP_BITS-1:0] tidx_q, tidx_d;
  logic [PASS_W-1:0]   pass_q, pass_d;
  logic [LEN_W-1:0]    len_q, len_d, mpos_q, mpos_d;
  logic [HIDX_W-1:0]   pos_q, pos_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                fast_q, fast_d, final_q, final_d;
  logic                ovf_q, ovf_d, ovalid_q, ovalid_d;
  logic                accept;
  logic                msg_done;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;
  assign msg_done    = (LEN_W'(mpos_q + 1'b1) == len_q);

  always_comb begin
    state_d  = state_q;
    tidx_d   = tidx_q;
    pass_d   = pass_q;
    len_d    = len_q;
    mpos_d   = mpos_q;
    pos_d    = pos_q;
    step_d   = step_q;
    fast_d   = fast_q;
    final_d  = final_q;
    ovf_d    = ovf_q;
    ovalid_d = ovalid_q;
    cmd_o.op   = CMD_IDLE;
    cmd_o.tidx = tidx_q;
    cmd_o.midx = len_q[MSG_AW-1:0];
    cmd_o.hidx = final_q ? pos_q : HIDX_W'(mpos_q);
    cmd_o.step = step_q;
    cmd_o.last = (pos_q == '0);
    cmd_o.ovf  = ovf_q;

    // result transaction taken
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_BUILD: begin
              cmd_o.op = CMD_GEN_INIT;
              tidx_d   = '0;
              state_d  = ST_FILL;
            end
            OP_ABSORB: begin
              if (len_q < LEN_W'(MAX_LEN)) begin
                cmd_o.op = CMD_MSG_WR;
                len_d    = LEN_W'(len_q + 1'b1);
              end else begin
                ovf_d = 1'b1;
              end
              if (last_byte_i) begin
                state_d = ST_HINIT;
              end
            end
            OP_FINISH: begin
              state_d = ST_HINIT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      // identity fill, one entry per cycle
      ST_FILL: begin
        cmd_o.op = CMD_FILL_WR;
        tidx_d   = MAP_BITS'(tidx_q + 1'b1);
        if (tidx_q == '1) begin
          pass_d  = '0;
          state_d = (passes_i == '0) ? ST_IDLE : ST_G0;
        end
      end
      // one swap: generator read, update, read i, read j, write i, write j
      ST_G0: begin
        cmd_o.op = CMD_GEN_RD;
        state_d  = ST_G1;
      end
      ST_G1: begin
        cmd_o.op = CMD_GEN_UPD;
        state_d  = ST_G2;
      end
      ST_G2: begin
        cmd_o.op = CMD_SW_RDJ;
        state_d  = ST_G3;
      end
      ST_G3: begin
        cmd_o.op = CMD_SW_WRI;
        state_d  = ST_G4;
      end
      ST_G4: begin
        cmd_o.op = CMD_SW_WRJ;
        tidx_d   = MAP_BITS'(tidx_q + 1'b1);
        state_d  = ST_G0;
        if (tidx_q == '1) begin
          pass_d = PASS_W'(pass_q + 1'b1);
          if (PASS_W'(pass_q + 1'b1) == passes_i) begin
            state_d = ST_IDLE;
          end
        end
      end
      // start of digest
      ST_HINIT: begin
        cmd_o.op = CMD_HASH_INIT;
        mpos_d   = '0;
        fast_d   = 1'b1;
        if (len_q == '0) begin
          final_d = 1'b1;
          pos_d   = LAST_POS;
          state_d = ST_FLD;
        end else begin
          final_d = 1'b0;
          state_d = ST_MRD;
        end
      end
      ST_MRD: begin
        cmd_o.op   = CMD_MSG_RD;
        cmd_o.midx = mpos_q[MSG_AW-1:0];
        state_d    = ST_MLD;
      end
      ST_MLD: begin
        cmd_o.op = CMD_LOAD_BYTE;
        step_d   = fast_q ? '0 : STEP_W'(1);
        state_d  = ST_XRD;
      end
      ST_XRD: begin
        cmd_o.op = CMD_MIX_RD;
        state_d  = ST_XUP;
      end
      ST_XUP: begin
        cmd_o.op = CMD_MIX_UPD;
        if (fast_q && !final_q) begin
          // fast step done, next byte or switch to full pass
          if (msg_done) begin
            fast_d  = 1'b0;
            mpos_d  = '0;
          end else begin
            mpos_d = LEN_W'(mpos_q + 1'b1);
          end
          state_d = ST_MRD;
        end else if (step_q == FULL_STEPS) begin
          state_d = ST_XEND;
        end else begin
          step_d  = STEP_W'(step_q + 1'b1);
          state_d = ST_XRD;
        end
      end
      ST_XEND: begin
        cmd_o.op = CMD_FULL_END;
        if (final_q) begin
          state_d = ST_O1;
        end else if (msg_done) begin
          final_d = 1'b1;
          pos_d   = LAST_POS;
          state_d = ST_FLD;
        end else begin
          mpos_d  = LEN_W'(mpos_q + 1'b1);
          state_d = ST_MRD;
        end
      end
      ST_FLD: begin
        cmd_o.op = CMD_LOAD_FINAL;
        fast_d   = 1'b0;
        step_d   = STEP_W'(1);
        state_d  = ST_XRD;
      end
      ST_O1: begin
        cmd_o.op = CMD_OUT_RD1;
        state_d  = ST_O2;
      end
      ST_O2: begin
        cmd_o.op = CMD_OUT_RD2;
        state_d  = ST_O3;
      end
      // load the output register once it is free
      ST_O3: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.op = CMD_OUT_SET;
          ovalid_d = 1'b1;
          if (pos_q == '0) begin
            len_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            pos_d   = HIDX_W'(pos_q - 1'b1);
            state_d = ST_FLD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tidx_q   <= '0;
      pass_q   <= '0;
      len_q    <= '0;
      mpos_q   <= '0;
      pos_q    <= '0;
      step_q   <= '0;
      fast_q   <= 1'b0;
      final_q  <= 1'b0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tidx_q   <= tidx_d;
      pass_q   <= pass_d;
      len_q    <= len_d;
      mpos_q   <= mpos_d;
      pos_q    <= pos_d;
      step_q   <= step_d;
      fast_q   <= fast_d;
      final_q  <= final_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

FILE: hw/rtl/lookup_xor_shift_hash.sv
// Build: identity fill of 2^MAP_BITS entries then passes * 2^MAP_BITS swaps (generator
// read, update, read i, read j, write i, write j). Absorb: one byte per cycle in idle.
// Digest of L buffered bytes: hash init, fast then full mix of every byte, then per
// output byte a final load, 25 table steps on the single table read port, end, output
// reads, an output set waiting for the output register. One item in flight at a time.
// Reset clears control and config; table and message ram are undefined, no clear.
module lookup_xor_shift_hash
  import lxr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lxr_in_if.sink               in_if,
  lxr_out_if.source            out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]          cfg_data_i
);

  logic [4:0]  passes_q;
  logic [63:0] seed_q;
  ctrl_cmd_t   cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      passes_q <= PASSES_RESET;
      seed_q   <= SEED_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PASSES: passes_q <= cfg_data_i[4:0];
        REG_SEED:   seed_q   <= cfg_data_i;
        default:    seed_q   <= seed_q;
      endcase
    end
  end

  lxr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .operation_i(in_if.operation),
    .last_byte_i(in_if.last_byte),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .passes_i   (passes_q),
    .cmd_o      (cmd)
  );

  lxr_datapath u_dp (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .seed_i            (seed_q),
    .msg_byte_i        (in_if.message_byte),
    .digest_byte_o     (out_if.digest_byte),
    .byte_position_o   (out_if.byte_position),
    .last_of_digest_o  (out_if.last_of_digest),
    .message_too_long_o(out_if.message_too_long)
  );

endmodule

FILE: hw/rtl/lxr_checker.sv
// lxr_checker: port-level assertions for the hash block, bound to the top
// watches the handshake and payload signals of lxr_if
module lxr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] digest_byte_i,
  input logic [4:0] byte_position_i,
  input logic       last_of_digest_i
);

  // the final byte of a digest is always position zero
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_of_digest_i |-> byte_position_i == 5'd0)
    else $error("last digest byte not at position zero");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(digest_byte_i) &&
    $stable(byte_position_i))
    else $error("stalled result changed");

  // no new transaction while a digest is still being produced
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_of_digest_i |-> !in_ready_i)
    else $error("input ready in the middle of a digest");

  // positions count down by one between results
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_of_digest_i ##1 out_valid_i |->
    byte_position_i == $past(byte_position_i) - 5'd1)
    else $error("digest position out of order");

endmodule

bind lookup_xor_shift_hash lxr_checker u_lxr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .digest_byte_i   (out_if.digest_byte),
  .byte_position_i (out_if.byte_position),
  .last_of_digest_i(out_if.last_of_digest)
);
